// File: design/sds_pkg.sv
// Shared types, constants and helpers for the stream delimiter splitter.
// No dependencies; every other file of the block but sds_ifs.sv refers to this package.
package sds_pkg;

  // Delimiter geometry
  localparam int MAX_DELIM_BYTES = 8;
  localparam int CNT_W = $clog2(MAX_DELIM_BYTES + 2);
  localparam int IDX_W = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1;
  localparam logic [3:0] MAX_LEN = 4'(MAX_DELIM_BYTES);

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  // Command queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // Include modes; anything at or above MODE_AFTER puts the delimiter after
  localparam logic [1:0] MODE_DROP   = 2'd0;
  localparam logic [1:0] MODE_BEFORE = 2'd1;
  localparam logic [1:0] MODE_AFTER  = 2'd2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DELIM_BYTES  = 2'd0,
    REG_DELIM_LENGTH = 2'd1,
    REG_INCLUDE_MODE = 2'd2
  } cfg_index_t;

  localparam logic [63:0] DELIM_BYTES_RST  = 64'd10;
  localparam logic [3:0]  DELIM_LENGTH_RST = 4'd1;
  localparam logic [1:0]  INCLUDE_MODE_RST = MODE_DROP;

  typedef struct packed {
    logic [63:0] delim_bytes;
    logic [3:0]  delim_length;
    logic [1:0]  include_mode;
  } cfg_t;

  // One queued command: cnt delimiter bytes plus an optional tail byte,
  // the tail going either first or last.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             has_tail;
    logic             tail_first;
    logic [7:0]       tail_byte;
  } cmd_t;

  // Delimiter byte at a position of the register
  function automatic logic [7:0] delim_at(logic [63:0] bytes, logic [IDX_W-1:0] pos);
    logic [5:0] base;
    base = {3'(pos), 3'b000};
    return bytes[base +: 8];
  endfunction

endpackage

// File: design/sds_ifs.sv
// Valid/ready channel interfaces of the stream delimiter splitter.
// Depends on nothing; the top level and its user connect through these.
interface sds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_end;
  modport source (output valid, output in_byte, output is_end, input ready);
  modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

interface sds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface sds_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/sds_front.sv
// Front part: accepts input beats, tracks the delimiter match and issues
// output commands. Depends on sds_pkg.
module sds_front (
  input  logic           clk,
  input  logic           rst_n,
  input  sds_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           is_end,
  input  logic           q_full,
  output logic           q_push,
  output sds_pkg::cmd_t  q_cmd
);

  logic [sds_pkg::CNT_W-1:0] matched_r, matched_nxt;
  logic [3:0]                len;
  logic [sds_pkg::CNT_W-1:0] len_c;
  logic                      accept;
  logic                      hit;
  logic                      done;

  // Saturate the delimiter length
  assign len   = (cfg.delim_length > sds_pkg::MAX_LEN) ? sds_pkg::MAX_LEN : cfg.delim_length;
  assign len_c = sds_pkg::CNT_W'(len);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Next byte of the delimiter matches
  assign hit  = !is_end && (matched_r < len_c) &&
                (in_byte == sds_pkg::delim_at(cfg.delim_bytes,
                                              matched_r[sds_pkg::IDX_W-1:0]));
  assign done = hit && ((matched_r + 1'b1) == len_c);

  // Classify the beat into a command
  always_comb begin
    matched_nxt        = matched_r;
    q_push             = 1'b0;
    q_cmd.cnt          = matched_r;
    q_cmd.has_tail     = 1'b0;
    q_cmd.tail_first   = 1'b0;
    q_cmd.tail_byte    = in_byte;
    if (accept) begin
      if (is_end) begin
        q_push      = (matched_r != '0);
        matched_nxt = '0;
      end else if (hit) begin
        if (done) begin
          q_push          = 1'b1;
          q_cmd.has_tail  = 1'b1;
          q_cmd.tail_byte = sds_pkg::NEWLINE_BYTE;
          if (cfg.include_mode == sds_pkg::MODE_DROP) begin
            q_cmd.cnt = '0;
          end else begin
            q_cmd.cnt        = len_c;
            q_cmd.tail_first = (cfg.include_mode >= sds_pkg::MODE_AFTER);
          end
          matched_nxt = '0;
        end else begin
          matched_nxt = matched_r + 1'b1;
        end
      end else begin
        q_push         = 1'b1;
        q_cmd.has_tail = 1'b1;
        matched_nxt    = '0;
      end
    end
  end

  // Hold the match count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r <= '0;
    end else begin
      matched_r <= matched_nxt;
    end
  end

endmodule

// File: design/sds_cmd_fifo.sv
// Short command queue between the front and back parts.
// Depends on sds_pkg for the command type and depth.
module sds_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sds_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output sds_pkg::cmd_t head
);

  sds_pkg::cmd_t                mem [sds_pkg::QUEUE_DEPTH];
  logic [sds_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [sds_pkg::QPTR_W:0]     count_r;
  logic                         do_push, do_pop;

  assign full    = (count_r == (sds_pkg::QPTR_W+1)'(sds_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  // Write the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: design/sds_back.sv
// Back part: expands queued commands into output beats, one per cycle while
// the receiver is ready, through a registered output stage. Depends on sds_pkg.
module sds_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [63:0]    delim_bytes,
  input  logic           q_empty,
  input  sds_pkg::cmd_t  q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last_of_run
);

  logic [sds_pkg::CNT_W-1:0] beat_r, beat_nxt;
  logic [sds_pkg::CNT_W-1:0] total;
  logic [sds_pkg::CNT_W-1:0] pos;
  logic                      valid_r, valid_nxt;
  logic [7:0]                byte_r, byte_nxt;
  logic                      last_r, last_nxt;
  logic                      load;
  logic                      is_tail;
  logic                      is_last;

  assign total   = q_head.cnt + sds_pkg::CNT_W'(q_head.has_tail);
  assign is_tail = q_head.has_tail &&
                   (q_head.tail_first ? (beat_r == '0) : (beat_r == q_head.cnt));
  assign pos     = (q_head.has_tail && q_head.tail_first) ? beat_r - 1'b1 : beat_r;
  assign is_last = (beat_r == total - 1'b1);
  assign load    = !q_empty && (!valid_r || out_ready);
  assign q_pop   = load && is_last;

  // Pick the next beat and step through the command
  always_comb begin
    beat_nxt  = beat_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    valid_nxt = valid_r && !out_ready;
    if (load) begin
      valid_nxt = 1'b1;
      last_nxt  = is_last;
      byte_nxt  = is_tail ? q_head.tail_byte
                          : sds_pkg::delim_at(delim_bytes, pos[sds_pkg::IDX_W-1:0]);
      beat_nxt  = is_last ? '0 : beat_r + 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      beat_r  <= beat_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid   = valid_r;
  assign out_byte    = byte_r;
  assign last_of_run = last_r;

endmodule

// File: design/stream_delimiter_splitter.sv
// Top level of the stream delimiter splitter: configuration registers,
// front part, command queue and back part. Depends on sds_pkg, sds_ifs and the part files.
//
// Usage:
//   in_ch  : input beats (in_byte, is_end); is_end flushes a held prefix.
//   out_ch : result beats (out_byte, last_of_run); a newline marks a split,
//            last_of_run flags the final beat caused by one input beat.
//   cfg_ch : register writes (index 0 delim_bytes, 1 delim_length,
//            2 include_mode); always ready, index 3 is ignored. Write only
//            while the block is idle.
// Path: the command of an accepted input beat is written into the queue, and
//   the back part then loads its result beats into the output stage.
// Throughput: one input beat per cycle while each beat makes at most one
//   result and out_ch.ready is high; a beat with k results, k up to
//   MAX_DELIM_BYTES + 1, holds the single registered output stage till all
//   leave. A four-entry queue absorbs bursts; in_ch.ready drops when full.
// Reset: match count, queue and output stage clear; registers take their
//   reset values (newline delimiter, length 1, delimiter dropped).
// Stall: while out_ch.ready is low the output beat holds, the queue fills
//   and then input is held off; nothing is lost.
module stream_delimiter_splitter (
  input  logic        clk,
  input  logic        rst_n,
  sds_in_if.sink      in_ch,
  sds_out_if.source   out_ch,
  sds_cfg_if.sink     cfg_ch
);

  sds_pkg::cfg_t cfg_r;
  sds_pkg::cmd_t push_cmd;
  sds_pkg::cmd_t head_cmd;
  logic          q_push, q_pop, q_full, q_empty;

  assign cfg_ch.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delim_bytes  <= sds_pkg::DELIM_BYTES_RST;
      cfg_r.delim_length <= sds_pkg::DELIM_LENGTH_RST;
      cfg_r.include_mode <= sds_pkg::INCLUDE_MODE_RST;
    end else if (cfg_ch.valid) begin
      unique case (sds_pkg::cfg_index_t'(cfg_ch.index))
        sds_pkg::REG_DELIM_BYTES:  cfg_r.delim_bytes  <= cfg_ch.data;
        sds_pkg::REG_DELIM_LENGTH: cfg_r.delim_length <= cfg_ch.data[3:0];
        sds_pkg::REG_INCLUDE_MODE: cfg_r.include_mode <= cfg_ch.data[1:0];
        default: ;
      endcase
    end
  end

  sds_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.in_byte),
    .is_end   (in_ch.is_end),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  sds_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  sds_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .delim_bytes (cfg_r.delim_bytes),
    .q_empty     (q_empty),
    .q_head      (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .last_of_run (out_ch.last_of_run)
  );

endmodule

// File: tb/stream_delimiter_splitter_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for stream_delimiter_splitter: a directed table, then random phases.
// Each phase sets the registers and checks every beat against an in-bench predictor.
// Depends on sds_pkg, the channel interfaces in sds_ifs.sv and the design top level.
module stream_delimiter_splitter_test;

  typedef struct packed {
    logic [7:0] bval;
    logic       is_last;
  } split_beat_t;

  typedef enum logic [1:0] {
    ROW_DATA = 2'd0,
    ROW_END  = 2'd1,
    ROW_CFG  = 2'd2
  } row_kind_t;

  // One directed step: a data or end beat, or a register write.
  // typed rows carry their expected result (none or a single beat) in the table.
  typedef struct packed {
    row_kind_t           kind;
    logic [7:0]          bval;
    sds_pkg::cfg_index_t idx;
    logic [63:0]         val;
    bit                  typed;
    int                  n;
    logic [7:0]          res;
  } stim_row_t;

  localparam logic [63:0] DIR_DELIM = 64'h00FF_8001_7F43_4241;
  localparam logic [15:0] STALL_PATTERN = 16'b1100_1010_0111_0001;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 37;

  localparam stim_row_t DIR_ROWS [36] = '{
    // reset setup: newline delimiter, length 1, delimiter dropped
    '{ROW_DATA, 8'h00, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 1, 8'h00},
    '{ROW_DATA, 8'hFF, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 1, 8'hFF},
    '{ROW_DATA, 8'h0A, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 1, sds_pkg::NEWLINE_BYTE},
    '{ROW_END,  8'h5A, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    // eight-byte delimiter, length above the maximum, delimiter before newline
    '{ROW_CFG,  8'h00, sds_pkg::REG_DELIM_BYTES,  DIR_DELIM, 1'b0, 0, 8'h00},
    '{ROW_CFG,  8'h00, sds_pkg::REG_DELIM_LENGTH, 64'hF,     1'b0, 0, 8'h00},
    '{ROW_CFG,  8'h00, sds_pkg::REG_INCLUDE_MODE, 64'h1,     1'b0, 0, 8'h00},
    '{ROW_DATA, 8'h41, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h42, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h43, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h7F, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h01, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h80, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'hFF, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h00, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b0, 0, 8'h00},
    // two-byte delimiter after the newline, then mode three
    '{ROW_CFG,  8'h00, sds_pkg::REG_DELIM_LENGTH, 64'h2,     1'b0, 0, 8'h00},
    '{ROW_CFG,  8'h00, sds_pkg::REG_INCLUDE_MODE, 64'h2,     1'b0, 0, 8'h00},
    '{ROW_DATA, 8'h41, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h42, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b0, 0, 8'h00},
    '{ROW_CFG,  8'h00, sds_pkg::REG_INCLUDE_MODE, 64'h3,     1'b0, 0, 8'h00},
    '{ROW_DATA, 8'h41, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h42, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b0, 0, 8'h00},
    // dropped delimiter: broken prefix with no restart, then an end flush
    '{ROW_CFG,  8'h00, sds_pkg::REG_INCLUDE_MODE, 64'h0,     1'b0, 0, 8'h00},
    '{ROW_DATA, 8'h41, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h41, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b0, 0, 8'h00},
    '{ROW_DATA, 8'h41, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_END,  8'hA5, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b0, 0, 8'h00},
    // shrink the length under a held prefix
    '{ROW_CFG,  8'h00, sds_pkg::REG_DELIM_LENGTH, 64'h8,     1'b0, 0, 8'h00},
    '{ROW_DATA, 8'h41, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h42, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h43, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_DATA, 8'h7F, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 0, 8'h00},
    '{ROW_CFG,  8'h00, sds_pkg::REG_DELIM_LENGTH, 64'h2,     1'b0, 0, 8'h00},
    '{ROW_DATA, 8'h55, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b0, 0, 8'h00},
    // length zero: everything passes through
    '{ROW_CFG,  8'h00, sds_pkg::REG_DELIM_LENGTH, 64'h0,     1'b0, 0, 8'h00},
    '{ROW_DATA, 8'h41, sds_pkg::REG_DELIM_BYTES,  64'd0,     1'b1, 1, 8'h41}
  };

  logic clk;
  logic rst_n;

  sds_in_if  in_if ();
  sds_out_if out_if ();
  sds_cfg_if cfg_if ();

  stream_delimiter_splitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Predictor copy of the registers and the match count
  logic [63:0] split_delim;
  logic [3:0]  split_len;
  logic [1:0]  split_mode;
  int          split_matched;

  split_beat_t fresh_beats[$];
  split_beat_t pending_beats[$];
  int          err_count;
  int          burst_left;
  bit          gapless;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function int active_len();
    return (split_len > sds_pkg::MAX_LEN) ? sds_pkg::MAX_DELIM_BYTES : int'(split_len);
  endfunction

  // Emit the held prefix, taken from the current delimiter register.
  function void flush_held();
    for (int i = 0; i < split_matched && i < sds_pkg::MAX_DELIM_BYTES; i++)
      fresh_beats.push_back('{split_delim[8*i +: 8], 1'b0});
  endfunction

  // Work out the result beats of one input beat into fresh_beats.
  function void predict_split(input logic [7:0] bval, input logic is_end);
    int len;
    len = active_len();
    fresh_beats.delete();
    if (is_end) begin
      flush_held();
      split_matched = 0;
    end else if (split_matched < len && bval == split_delim[8*split_matched +: 8]) begin
      split_matched++;
      if (split_matched == len) begin
        if (split_mode == sds_pkg::MODE_BEFORE) flush_held();
        fresh_beats.push_back('{sds_pkg::NEWLINE_BYTE, 1'b0});
        if (split_mode >= sds_pkg::MODE_AFTER) flush_held();
        split_matched = 0;
      end
    end else begin
      flush_held();
      fresh_beats.push_back('{bval, 1'b0});
      split_matched = 0;
    end
    if (fresh_beats.size() > 0) fresh_beats[fresh_beats.size()-1].is_last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    err_count++;
  endtask

  // Hold the input off until every expected beat has come out.
  task automatic drain_results();
    in_if.valid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(input sds_pkg::cfg_index_t idx, input logic [63:0] val);
    drain_results();
    repeat (6) @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      sds_pkg::REG_DELIM_BYTES:  split_delim = val;
      sds_pkg::REG_DELIM_LENGTH: split_len = val[3:0];
      sds_pkg::REG_INCLUDE_MODE: split_mode = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Send one input beat inside the current burst; queue its expected results.
  task automatic feed(input logic [7:0] bval, input logic is_end, input bit typed,
                      input int tn, input logic [7:0] tres);
    if (burst_left == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = gapless ? 1_000_000 : $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid   = 1'b1;
    in_if.in_byte = bval;
    in_if.is_end  = is_end;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_split(bval, is_end);
    if (typed) begin
      if (tn > 0) pending_beats.push_back('{tres, 1'b1});
    end else begin
      foreach (fresh_beats[i]) pending_beats.push_back(fresh_beats[i]);
    end
    @(negedge clk);
  endtask

  // Receiver: drive out_if.ready in one of four stall styles, picked anew at random
  initial begin
    int cyc;
    int style;
    cyc = 0;
    style = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 48 == 0) style = $urandom_range(0, 3);
      case (style)
        0: out_if.ready = 1'b1;
        1: out_if.ready = 1'($urandom_range(0, 1));
        2: out_if.ready = ($urandom_range(0, 3) == 0);
        default: out_if.ready = STALL_PATTERN[cyc % 16];
      endcase
      cyc++;
    end
  end

  // Check each output beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected beat", int'(out_if.out_byte), 0);
      end else begin
        split_beat_t want;
        want = pending_beats.pop_front();
        if (out_if.out_byte !== want.bval)
          report_mismatch("out_byte", int'(out_if.out_byte), int'(want.bval));
        if (out_if.last_of_run !== want.is_last)
          report_mismatch("last_of_run", int'(out_if.last_of_run), int'(want.is_last));
      end
    end
  end

  initial begin
    logic [63:0] pb;
    logic [63:0] wv;
    logic [3:0]  pl;
    logic [1:0]  pm;
    logic [7:0]  bval;
    logic        is_end;
    int          r;
    int          pos;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.is_end = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = sds_pkg::REG_DELIM_BYTES;
    cfg_if.data = 64'd0;
    split_delim = sds_pkg::DELIM_BYTES_RST;
    split_len = sds_pkg::DELIM_LENGTH_RST;
    split_mode = sds_pkg::INCLUDE_MODE_RST;
    split_matched = 0;
    err_count = 0;
    burst_left = 0;
    gapless = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (DIR_ROWS[i]) begin
      case (DIR_ROWS[i].kind)
        ROW_CFG: write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].val);
        default: feed(DIR_ROWS[i].bval, DIR_ROWS[i].kind == ROW_END, DIR_ROWS[i].typed,
                      DIR_ROWS[i].n, DIR_ROWS[i].res);
      endcase
    end

    // Random phases, each with its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      pb = {$urandom, $urandom};
      case (p)
        0: begin pl = 4'd1;  pm = sds_pkg::MODE_DROP;   end
        1: begin pl = 4'd8;  pm = sds_pkg::MODE_BEFORE; end
        2: begin pb = '1;    pl = 4'd3;  pm = sds_pkg::MODE_AFTER; end
        3: begin pb = '0;    pl = 4'd15; pm = 2'd3; end
        4: begin pl = 4'd0;  pm = sds_pkg::MODE_BEFORE; end
        5: begin pb = 64'h6161_6161_6161_6161; pl = 4'd4; pm = sds_pkg::MODE_BEFORE; end
        default: begin pl = 4'($urandom_range(0, 15)); pm = 2'($urandom_range(0, 3)); end
      endcase
      write_reg(sds_pkg::REG_DELIM_BYTES, pb);
      wv = {$urandom, $urandom};
      wv[3:0] = pl;
      write_reg(sds_pkg::REG_DELIM_LENGTH, wv);
      wv = {$urandom, $urandom};
      wv[1:0] = pm;
      write_reg(sds_pkg::REG_INCLUDE_MODE, wv);
      gapless = (p % 4 == 3);
      burst_left = 0;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 4 && k == PHASE_ITEMS / 2) drain_results();
        r = $urandom_range(0, 99);
        is_end = (r < 5);
        // mostly extend the match, else break it with delimiter or noise bytes
        if (r < 65 && split_matched < active_len()) begin
          bval = split_delim[8*split_matched +: 8];
        end else if (r < 80) begin
          pos = $urandom_range(0, 7);
          bval = split_delim[8*pos +: 8];
        end else if ($urandom_range(0, 1)) begin
          bval = 8'($urandom_range(0, 255));
        end else begin
          bval = 8'(8'h40 + $urandom_range(0, 3));
        end
        feed(bval, is_end, 1'b0, 0, 8'h00);
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
